/* rtl/robe_pkg.sv */
package robe_pkg;

   localparam int CANVAS_PIXELS = 65536;
   localparam int ADDR_W = $clog2(CANVAS_PIXELS);
   localparam int IDX_W = 22;

   // floor(d*256/65025) as (d*ALPHA_RECIP) >> ALPHA_SHIFT, exact for d up to 65025
   localparam logic [25:0] ALPHA_RECIP = 26'd33818121;
   localparam int ALPHA_SHIFT = 33;

   typedef enum logic [1:0] {
      ACT_PLACE = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_CANVAS_WIDTH  = 3'd0,
      REG_ORIGIN_X      = 3'd1,
      REG_ORIGIN_Y      = 3'd2,
      REG_PATCH_WIDTH   = 3'd3,
      REG_CHANNEL_COUNT = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INDEX,
      ST_READ,
      ST_DIV,
      ST_WRITE,
      ST_EMIT
   } state_type;

endpackage

/* rtl/rgba_over_blit_engine.sv */
// channel   ports                                   beat accepted when
// command   start, busy, req_*                      start & !busy
// result    rsp_strobe, rsp_*                       rsp_strobe (one cycle, no stall)
// config    psel, penable, pwrite, paddr, pwdata,   psel & penable & pwrite & pready
//           prdata, pready
//
// a write, read or unblended place beat steps from accept through index, memory read,
// write-back and result before the next accept; an out-of-range place skips write-back
// a blended place with any alpha adds a divide step: three colour channels go through
// the shared divider in turn (load, 24 quotient bits, done)
// reset is synchronous; the canvas has no reset and must be written first
// busy stays high from accept until the result strobe; the receiver cannot stall
module rgba_over_blit_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic                  req_first_of_patch,
   input  logic [15:0]           req_pixel_addr,
   input  logic [7:0]            req_chan0,
   input  logic [7:0]            req_chan1,
   input  logic [7:0]            req_chan2,
   input  logic [7:0]            req_chan3,
   output logic                  rsp_strobe,
   output logic [15:0]           rsp_pixel_index,
   output logic [7:0]            rsp_out_chan0,
   output logic [7:0]            rsp_out_chan1,
   output logic [7:0]            rsp_out_chan2,
   output logic [7:0]            rsp_out_chan3,
   output logic                  rsp_out_of_range,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import robe_pkg::*;

   // configuration registers
   logic [10:0] cw_ff;
   logic [9:0]  ox_ff, oy_ff;
   logic [10:0] pw_ff;
   logic [2:0]  cc_ff;
   logic [2:0]  reg_sel;

   assign pready = 1'b1;
   assign reg_sel = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= 11'd256;
         ox_ff <= '0;
         oy_ff <= '0;
         pw_ff <= 11'd1;
         cc_ff <= 3'd4;
      end else if (psel && penable && pwrite) begin
         case (reg_sel)
            REG_CANVAS_WIDTH:  cw_ff <= pwdata[10:0];
            REG_ORIGIN_X:      ox_ff <= pwdata[9:0];
            REG_ORIGIN_Y:      oy_ff <= pwdata[9:0];
            REG_PATCH_WIDTH:   pw_ff <= pwdata[10:0];
            REG_CHANNEL_COUNT: cc_ff <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_CANVAS_WIDTH:  prdata = {21'd0, cw_ff};
         REG_ORIGIN_X:      prdata = {22'd0, ox_ff};
         REG_ORIGIN_Y:      prdata = {22'd0, oy_ff};
         REG_PATCH_WIDTH:   prdata = {21'd0, pw_ff};
         REG_CHANNEL_COUNT: prdata = {29'd0, cc_ff};
         default:           prdata = '0;
      endcase
   end

   // canvas memory, one read and one write port sharing a single address
   logic [31:0] canvas_mem [CANVAS_PIXELS];
   logic [31:0] rd_ff;
   logic        mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [31:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) canvas_mem[mem_addr] <= mem_wdata;
      rd_ff <= canvas_mem[mem_addr];
   end

   // beat registers
   state_type   st_ff, st_in;
   logic [1:0]  act_ff;
   logic [31:0] src_ff;
   logic [9:0]  col_ff, row_ff;
   logic [IDX_W-1:0] idx_ff;
   logic        oor_ff;
   logic [31:0] res_ff, res_in;
   logic [1:0]  k_ff;
   logic        dstart_ff;
   logic [17:0] ws_ff, wd_ff;
   logic [17:0] den;
   logic [23:0] dnum;
   logic        ddone;
   logic [23:0] dq;
   logic [7:0]  cs, cd;
   logic        accept;
   logic [9:0]  col_use, row_use;
   logic [10:0] col_next;
   logic        any_alpha;

   assign accept = start && (st_ff == ST_IDLE);
   assign busy = (st_ff != ST_IDLE);
   assign col_use = (req_first_of_patch) ? 10'd0 : col_ff;
   assign row_use = (req_first_of_patch) ? 10'd0 : row_ff;
   assign col_next = {1'b0, col_use} + 11'd1;
   // both alphas zero means a zero denominator: colour and alpha fall to 0
   assign any_alpha = (src_ff[31:24] != 8'd0) || (rd_ff[31:24] != 8'd0);
   assign den = ws_ff + wd_ff;
   assign cs = src_ff[8*k_ff +: 8];
   assign cd = rd_ff[8*k_ff +: 8];
   // colour numerator fits 24 bits: at most 255*65025 < 2^24
   assign dnum = 24'(ws_ff) * 24'(cs) + 24'(wd_ff) * 24'(cd);

   robe_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart_ff),
      .dividend (dnum),
      .divisor  (den),
      .done     (ddone),
      .quotient (dq)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:  if (accept && req_action != ACT_NONE) st_in = ST_INDEX;
         ST_INDEX: st_in = ST_READ;
         ST_READ:  begin
            if (oor_ff) st_in = ST_EMIT;
            else if (act_ff == ACT_PLACE && cc_ff == 3'd4 && any_alpha)
               st_in = ST_DIV;
            else st_in = ST_WRITE;
         end
         ST_DIV:   if (ddone && k_ff == 2'd2) st_in = ST_WRITE;
         ST_WRITE: st_in = ST_EMIT;
         ST_EMIT:  st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // memory port and result forming
   logic [31:0] mask;
   logic [43:0] alpha_prod;
   logic [8:0]  alpha_q;
   logic [7:0]  alpha;
   always_comb begin
      mem_we = 1'b0;
      mem_addr = idx_ff[ADDR_W-1:0];
      mem_wdata = res_ff;
      res_in = res_ff;
      case (cc_ff)
         3'd1: mask = 32'h0000_00ff;
         3'd2: mask = 32'h0000_ffff;
         3'd3: mask = 32'h00ff_ffff;
         default: mask = 32'h0;
      endcase
      // alpha = floor(den*256/65025) by reciprocal multiply, saturated
      alpha_prod = 44'(den) * 44'(ALPHA_RECIP);
      alpha_q = alpha_prod[ALPHA_SHIFT +: 9];
      alpha = (alpha_q > 9'd255) ? 8'd255 : alpha_q[7:0];
      case (st_ff)
         ST_READ: begin
            if (act_ff == ACT_WRITE) res_in = src_ff;
            else if (act_ff == ACT_READ) res_in = rd_ff;
            else if (cc_ff == 3'd4) res_in = 32'd0;
            else if (cc_ff >= 3'd1 && cc_ff <= 3'd3)
               res_in = (src_ff & mask) | (rd_ff & ~mask);
            else res_in = rd_ff;
         end
         ST_DIV: begin
            res_in[31:24] = alpha;
            if (ddone)
               res_in[8*k_ff +: 8] = (dq > 24'd255) ? 8'd255 : dq[7:0];
         end
         ST_WRITE: mem_we = (act_ff != ACT_READ);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (accept) begin
         act_ff <= req_action;
         src_ff <= {req_chan3, req_chan2, req_chan1, req_chan0};
      end
      // blend weights from the source alpha and the destination read back in this state
      if (st_ff == ST_READ) begin
         ws_ff <= 18'(src_ff[31:24]) * 18'd255;
         wd_ff <= 18'(rd_ff[31:24]) * 18'(8'd255 - src_ff[31:24]);
      end
      if (reset) begin
         st_ff <= ST_IDLE;
         col_ff <= '0;
         row_ff <= '0;
         dstart_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         st_ff <= st_in;
         dstart_ff <= 1'b0;
         if (accept && req_action == ACT_PLACE) begin
            idx_ff <= 22'(11'(oy_ff) + 11'(row_use)) * 22'(cw_ff)
                      + 22'(ox_ff) + 22'(col_use);
            // column wraps at the patch width or 1024, width 0 acts as 1
            if (col_next >= pw_ff || col_next >= 11'd1024) begin
               col_ff <= '0;
               row_ff <= row_use + 10'd1;
            end else begin
               col_ff <= col_use + 10'd1;
               row_ff <= row_use;
            end
         end else if (accept) begin
            idx_ff <= 22'(req_pixel_addr);
         end
         if (st_ff == ST_INDEX) oor_ff <= (idx_ff >= 22'(CANVAS_PIXELS));
         if (st_ff == ST_READ && st_in == ST_DIV) begin
            dstart_ff <= 1'b1;
            k_ff <= '0;
         end
         if (st_ff == ST_DIV && ddone && k_ff != 2'd2) begin
            k_ff <= k_ff + 2'd1;
            dstart_ff <= 1'b1;
         end
      end
   end

   // result port
   assign rsp_strobe = (st_ff == ST_EMIT);
   assign rsp_pixel_index = idx_ff[15:0];
   assign rsp_out_of_range = oor_ff;
   assign rsp_out_chan0 = oor_ff ? 8'd0 : res_ff[7:0];
   assign rsp_out_chan1 = oor_ff ? 8'd0 : res_ff[15:8];
   assign rsp_out_chan2 = oor_ff ? 8'd0 : res_ff[23:16];
   assign rsp_out_chan3 = oor_ff ? 8'd0 : res_ff[31:24];
endmodule

/* rtl/robe_divider.sv */
// restoring divider, one quotient bit per cycle, 24-bit quotient
module robe_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] dividend,
   input  logic [17:0] divisor,
   output logic        done,
   output logic [23:0] quotient
);
   logic [23:0] q_ff, q_in;
   logic [17:0] r_ff, r_in;
   logic [17:0] d_ff, d_in;
   logic [4:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [18:0] trial;
   logic [18:0] diff;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = '0;
      diff = '0;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         n_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, q_ff[23]};
         diff = trial - {1'b0, d_ff};
         if (trial >= {1'b0, d_ff}) begin
            r_in = diff[17:0];
            q_in = {q_ff[22:0], 1'b1};
         end else begin
            r_in = trial[17:0];
            q_in = {q_ff[22:0], 1'b0};
         end
         n_in = n_ff + 5'd1;
         if (n_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule
